@@ rtl/mrfe_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers for the meter register frame engine.
// No dependencies; every other file of the block imports this package.
package mrfe_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int FRAME_IDX_W = $clog2(FRAME_BYTES);
  localparam logic [FRAME_IDX_W-1:0] FRAME_LAST = FRAME_IDX_W'(FRAME_BYTES - 1);

  localparam logic [7:0] CS_OFFSET     = 8'h33;
  localparam logic [7:0] HEAD_RESET    = 8'd125;
  localparam logic [7:0] READ_RESET    = 8'd1;
  localparam logic [7:0] WRITE_RESET   = 8'd2;

  // Input item kinds
  typedef enum logic [1:0] {
    IK_READ    = 2'd0,
    IK_WRITE   = 2'd1,
    IK_RX      = 2'd2,
    IK_TIMEOUT = 2'd3
  } in_kind_e;

  // Result item kinds
  typedef enum logic [1:0] {
    OK_TX    = 2'd0,
    OK_VALUE = 2'd1,
    OK_FAIL  = 2'd2
  } out_kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HEAD  = 2'd0,
    CFG_READ  = 2'd1,
    CFG_WRITE = 2'd2
  } cfg_index_e;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // One accepted item's work: either a whole transmit frame or a single result
  typedef struct packed {
    logic        is_frame;
    frame_t      frame;
    out_kind_e   kind;
    logic [30:0] value;
  } job_t;

  // Result of the receive checker for the closing byte of a reply
  typedef struct packed {
    logic        fire;
    out_kind_e   kind;
    logic [30:0] value;
  } rx_res_t;

  // Frame checksum: inverted byte sum plus a fixed offset
  function automatic logic [7:0] frame_check(input logic [7:0] sum);
    frame_check = 8'(~sum + CS_OFFSET);
  endfunction

endpackage

@@ rtl/mrfe_tx_frame.sv @@
`timescale 1ns / 1ps
// Builds the eight bytes of a register read or write request frame.
// Depends on mrfe_pkg for the frame type and checksum helper.
module mrfe_tx_frame import mrfe_pkg::*; (
  input  logic        is_read,
  input  logic [11:0] reg_addr,
  input  logic [31:0] write_data,
  input  logic [7:0]  frame_head,
  input  logic [7:0]  read_code,
  input  logic [7:0]  write_code,
  output frame_t      frame
);

  logic [31:0] data;
  logic [7:0]  code;

  // Reads carry zero data and the read code
  assign data = is_read ? 32'd0 : write_data;
  assign code = is_read ? read_code : write_code;

  // Lay out header, command, address, little-endian data, then checksum
  always_comb begin
    logic [7:0] sum;
    sum = 8'd0;
    frame[0] = frame_head;
    frame[1] = 8'({reg_addr[11:8], 4'b0000} + code);
    frame[2] = reg_addr[7:0];
    frame[3] = data[7:0];
    frame[4] = data[15:8];
    frame[5] = data[23:16];
    frame[6] = data[31:24];
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      sum = 8'(sum + frame[i]);
    end
    frame[FRAME_BYTES-1] = frame_check(sum);
  end

endmodule

@@ rtl/mrfe_rx_check.sv @@
`timescale 1ns / 1ps
// Gathers received reply bytes, checks header, read code and checksum,
// and gives the saturated absolute data value. Depends on mrfe_pkg.
module mrfe_rx_check import mrfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_en,
  input  logic       clear,
  input  logic [7:0] rx_byte,
  input  logic [7:0] frame_head,
  input  logic [7:0] read_code,
  output rx_res_t    res
);

  logic [FRAME_IDX_W-1:0] rx_count;
  logic [7:0]             rx_sum;
  logic                   rx_frame_ok;
  logic [31:0]            rx_data;

  logic        closing;
  logic        good;
  logic [31:0] neg_data;
  logic [30:0] abs_val;
  logic [1:0]  byte_sel;

  assign closing  = byte_en && (rx_count == FRAME_LAST);
  assign good     = rx_frame_ok && (rx_byte == frame_check(rx_sum));
  assign neg_data = 32'(~rx_data + 32'd1);
  assign byte_sel = 2'(rx_count - FRAME_IDX_W'(3));

  // Absolute value, with the most negative word saturated
  always_comb begin
    if (!rx_data[31]) begin
      abs_val = rx_data[30:0];
    end else if (rx_data[30:0] == 31'd0) begin
      abs_val = '1;
    end else begin
      abs_val = neg_data[30:0];
    end
  end

  always_comb begin
    res.fire  = closing;
    res.kind  = good ? OK_VALUE : OK_FAIL;
    res.value = good ? abs_val : 31'd0;
  end

  // Advance the gathering state, or drop it on clear and on the closing byte
  always_ff @(posedge clk) begin
    if (rst || clear || closing) begin
      rx_count    <= '0;
      rx_sum      <= '0;
      rx_frame_ok <= 1'b1;
      rx_data     <= '0;
    end else if (byte_en) begin
      if (rx_count == FRAME_IDX_W'(0) && rx_byte != frame_head) begin
        rx_frame_ok <= 1'b0;
      end
      if (rx_count == FRAME_IDX_W'(1) && rx_byte != read_code) begin
        rx_frame_ok <= 1'b0;
      end
      if (rx_count >= FRAME_IDX_W'(3)) begin
        rx_data[{byte_sel, 3'b000} +: 8] <= rx_byte;
      end
      rx_sum   <= 8'(rx_sum + rx_byte);
      rx_count <= FRAME_IDX_W'(rx_count + FRAME_IDX_W'(1));
    end
  end

endmodule

@@ rtl/mrfe_out_seq.sv @@
`timescale 1ns / 1ps
// Holds one job and steps its results into the output register,
// one result a cycle while the output is not stalled. Depends on mrfe_pkg for the job type and codes.
module mrfe_out_seq import mrfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  job_t        job_in,
  output logic        can_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [30:0] read_value
);

  logic                   job_valid;
  job_t                   job;
  logic [FRAME_IDX_W-1:0] idx;

  logic out_free;
  logic job_last;
  logic move;

  assign out_free = !out_valid || !out_stall;
  assign job_last = !job.is_frame || (idx == FRAME_LAST);
  assign move     = job_valid && out_free;
  assign can_take = !job_valid || (move && job_last);

  // Job buffer: load a new job, advance the byte index, release after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (move && job_last) begin
      job_valid <= 1'b0;
    end else if (move) begin
      idx <= FRAME_IDX_W'(idx + FRAME_IDX_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

  // Output register: hold while stalled, take the next result when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      if (job.is_frame) begin
        out_kind   <= OK_TX;
        tx_byte    <= job.frame[idx];
        last       <= (idx == FRAME_LAST);
        read_value <= '0;
      end else begin
        out_kind   <= job.kind;
        tx_byte    <= '0;
        last       <= 1'b1;
        read_value <= job.value;
      end
    end
  end

endmodule

@@ rtl/meter_register_frame_engine_core.sv @@
`timescale 1ns / 1ps
// Top level of the meter register frame engine.
// Depends on mrfe_pkg, mrfe_tx_frame, mrfe_rx_check and mrfe_out_seq.

// A read or write request is turned into an eight-byte frame in the cycle it
// is accepted and then leaves through the output register one byte a cycle
// while the output is not stalled; the next item is taken in the cycle the
// last byte of the frame moves to the output register. A received byte that
// closes a reply, or a timeout, gives one result; other received bytes give
// none. The first result of any item passes through the job buffer and then
// the output register. Configuration writes are taken at any time
// (cfg_ready is always high) but should only be issued while the block is
// idle.
module meter_register_frame_engine_core import mrfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [11:0] reg_addr,
  input  logic [31:0] write_data,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [30:0] read_value,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] frame_head;
  logic [7:0] read_code;
  logic [7:0] write_code;

  logic    can_take;
  logic    accept;
  logic    is_req;
  logic    rx_clear;
  logic    byte_en;
  logic    load;
  frame_t  frame;
  rx_res_t rx_res;
  job_t    job_in;

  assign cfg_ready = 1'b1;
  assign in_stall  = !can_take;
  assign accept    = in_valid && can_take;
  assign is_req    = (kind == IK_READ) || (kind == IK_WRITE);
  assign rx_clear  = accept && ((kind == IK_READ) || (kind == IK_TIMEOUT));
  assign byte_en   = accept && (kind == IK_RX);
  assign load      = accept && (kind != IK_RX || rx_res.fire);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_head <= HEAD_RESET;
      read_code  <= READ_RESET;
      write_code <= WRITE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAD:  frame_head <= cfg_data;
        CFG_READ:  read_code  <= cfg_data;
        CFG_WRITE: write_code <= cfg_data;
        default: ;
      endcase
    end
  end

  mrfe_tx_frame u_tx_frame (
    .is_read    (kind == IK_READ),
    .reg_addr   (reg_addr),
    .write_data (write_data),
    .frame_head (frame_head),
    .read_code  (read_code),
    .write_code (write_code),
    .frame      (frame)
  );

  mrfe_rx_check u_rx_check (
    .clk        (clk),
    .rst        (rst),
    .byte_en    (byte_en),
    .clear      (rx_clear),
    .rx_byte    (rx_byte),
    .frame_head (frame_head),
    .read_code  (read_code),
    .res        (rx_res)
  );

  // Select the job for the accepted request
  always_comb begin
    job_in.is_frame = is_req;
    job_in.frame    = frame;
    if (kind == IK_TIMEOUT) begin
      job_in.kind  = OK_FAIL;
      job_in.value = '0;
    end else begin
      job_in.kind  = rx_res.kind;
      job_in.value = rx_res.value;
    end
  end

  mrfe_out_seq u_out_seq (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .job_in     (job_in),
    .can_take   (can_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .tx_byte    (tx_byte),
    .last       (last),
    .read_value (read_value)
  );

`ifndef SYNTHESIS
  // Value and failure results always close their item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != OK_TX |-> last)
    else $error("single result without last");

  // Only a good read reply carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != OK_VALUE |-> read_value == 31'd0)
    else $error("non-zero value outside a good reply");

  // Nothing is presented straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented after reset");
`endif

endmodule
